// ===== rtl/core/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, operation codes and cell bus types for the lru key/value
// cache core.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_W           = 32;
   localparam int VAL_W           = 32;
   localparam int CAP_W           = 5;
   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef logic [1:0] op_type;

   localparam op_type OP_NONE   = 2'd0;
   localparam op_type OP_HIT    = 2'd1;
   localparam op_type OP_EVICT  = 2'd2;
   localparam op_type OP_INSERT = 2'd3;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             eval;
      logic             update;
      op_type           op;
      logic             write_value;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } cell_cmd_type;

   // accumulated along the row, one cell to the next
   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] hit_value;
      logic [KEY_W-1:0] lru_key;
   } cell_scan_type;

endpackage

// ===== rtl/core/lkvc_cell.sv =====
// ----------------------------------------------------------------------------
// lkvc_cell
// One cache slot: key, value, valid mark and recency rank, with its own key
// compare, lru detect and rank update. Scan results pass to the next cell.
// ----------------------------------------------------------------------------
module lkvc_cell
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT,
   parameter int CELL_ID = 0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cell_cmd_type                             cmd_i,
   input  logic [$clog2(ENTRIES+1)-1:0]             count_i,
   input  logic [$clog2(ENTRIES+1)-1:0]             ref_rank_i,
   input  cell_scan_type                            scan_i,
   output cell_scan_type                            scan_o,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_rank_i,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_rank_o
);

   localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic             valid_ff, valid_in;
   logic [RW-1:0]    rank_ff, rank_in;
   logic             hit_ff, hit_in;
   logic             lru_ff, lru_in;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [CW-1:0]    rank_ext;
   logic             is_free;
   logic             target;

   assign rank_ext = CW'(rank_ff);
   // slots fill in index order and are never released
   assign is_free  = (count_i == CW'(CELL_ID));

   assign target = ((cmd_i.op == OP_HIT)    && hit_ff) ||
                   ((cmd_i.op == OP_EVICT)  && lru_ff) ||
                   ((cmd_i.op == OP_INSERT) && is_free);

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      hit_in   = hit_ff;
      lru_in   = lru_ff;
      if (cmd_i.eval) begin
         hit_in = valid_ff && (key_ff == cmd_i.key);
         // ranks of valid slots are a permutation of 0 .. count-1
         lru_in = valid_ff && (rank_ext == (count_i - CW'(1)));
      end
      if (cmd_i.update && (cmd_i.op != OP_NONE)) begin
         if (target) begin
            valid_in = 1'b1;
            rank_in  = '0;
         end else if (valid_ff && (rank_ext < ref_rank_i)) begin
            rank_in = rank_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         hit_ff   <= 1'b0;
         lru_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         hit_ff   <= hit_in;
         lru_ff   <= lru_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.update && (cmd_i.op != OP_NONE) && target) begin
         key_ff <= cmd_i.key;
         if (cmd_i.write_value) begin
            value_ff <= cmd_i.value;
         end
      end
   end

   assign scan_o.hit       = scan_i.hit | hit_ff;
   assign scan_o.hit_value = scan_i.hit_value | (hit_ff ? value_ff : '0);
   assign scan_o.lru_key   = scan_i.lru_key | (lru_ff ? key_ff : '0);
   assign hit_rank_o       = hit_rank_i | (hit_ff ? rank_ff : '0);

endmodule

// ===== rtl/core/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with lru replacement, built as a row of
// slot cells that compare and re-rank in parallel.
// ----------------------------------------------------------------------------
// a request word is registered, the cells compare keys in the eval state, then the scan and
// update state registers the result word; while a word is in flight, the next is taken only there
// a full output register stalls the update cycle until the word is taken
// reset: all slots invalid, ranks zero, capacity 16; no clearing pass
module lru_key_value_cache_core
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_found,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_evicted,
   output logic signed [KEY_W-1:0] rsp_evicted_key,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CAP_W-1:0]        csr_capacity
);

   localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             mode_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [CAP_W-1:0] capacity_ff;

   logic             rsp_valid_ff;
   logic             found_ff, found_in;
   logic [VAL_W-1:0] read_value_ff, read_value_in;
   logic             evicted_ff, evicted_in;
   logic [KEY_W-1:0] evicted_key_ff, evicted_key_in;

   logic             slot_free;
   logic             req_take;
   logic             do_update;
   logic [CAPW-1:0]  cap_ext;
   logic [CAPW-1:0]  cap_eff;
   logic             need_evict;
   op_type           op;
   logic [CW-1:0]    ref_rank;
   cell_cmd_type     cmd;

   cell_scan_type    scan [ENTRIES+1];
   logic [RW-1:0]    hit_rank [ENTRIES+1];

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_UPD) && slot_free));
   assign req_take  = req_valid && !req_stall;
   assign do_update = (state_ff == ST_UPD) && slot_free;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (slot_free) state_in = req_take ? ST_EVAL : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // capacity zero acts as one; above ENTRIES the full check covers it
   assign cap_ext    = CAPW'(capacity_ff);
   assign cap_eff    = (cap_ext == '0) ? CAPW'(1) : cap_ext;
   assign need_evict = (count_ff == CW'(ENTRIES)) || (CAPW'(count_ff) >= cap_eff);

   always_comb begin
      op             = OP_NONE;
      ref_rank       = '0;
      count_in       = count_ff;
      found_in       = 1'b0;
      read_value_in  = '0;
      evicted_in     = 1'b0;
      evicted_key_in = '0;
      if (scan[ENTRIES].hit) begin
         op       = OP_HIT;
         ref_rank = CW'(hit_rank[ENTRIES]);
         found_in = 1'b1;
         if (!mode_ff) read_value_in = scan[ENTRIES].hit_value;
      end else if (mode_ff) begin
         if (need_evict) begin
            op             = OP_EVICT;
            ref_rank       = count_ff - CW'(1);
            evicted_in     = 1'b1;
            evicted_key_in = scan[ENTRIES].lru_key;
         end else begin
            op       = OP_INSERT;
            ref_rank = count_ff;
            count_in = count_ff + CW'(1);
         end
      end
   end

   assign cmd.eval        = (state_ff == ST_EVAL);
   assign cmd.update      = do_update;
   assign cmd.op          = op;
   assign cmd.write_value = mode_ff;
   assign cmd.key         = key_ff;
   assign cmd.value       = value_ff;

   assign scan[0]     = '0;
   assign hit_rank[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkvc_cell #(
         .ENTRIES (ENTRIES),
         .CELL_ID (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd_i      (cmd),
         .count_i    (count_ff),
         .ref_rank_i (ref_rank),
         .scan_i     (scan[i]),
         .scan_o     (scan[i+1]),
         .hit_rank_i (hit_rank[i]),
         .hit_rank_o (hit_rank[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_update) count_ff <= count_in;
         if (csr_valid && csr_ready) capacity_ff <= csr_capacity;
         if (do_update) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (do_update) begin
         found_ff       <= found_in;
         read_value_ff  <= read_value_in;
         evicted_ff     <= evicted_in;
         evicted_key_ff <= evicted_key_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

endmodule
